@@ design/mtpc_pkg.sv @@
package mtpc_pkg;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 40;
  localparam int CNT_W   = 32;
  localparam int DIFF_W  = 6;
  localparam int CMD_W   = 2;
  localparam int MODE_W  = 2;
  localparam int CLS_W   = 2;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  localparam int REG_W   = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [CLS_W-1:0]  cls_t;
  typedef logic [REG_W-1:0]  reg_idx_t;

  localparam cmd_t CMD_GEN   = 2'd0;
  localparam cmd_t CMD_CHECK = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  localparam mode_t MODE_OFFSET = 2'd0;
  localparam mode_t MODE_ALT    = 2'd1;
  localparam mode_t MODE_FIXED  = 2'd2;

  localparam cls_t CLS_NONE   = 2'd0;
  localparam cls_t CLS_SINGLE = 2'd1;
  localparam cls_t CLS_MULTI  = 2'd2;

  localparam reg_idx_t REG_BASE  = 2'd0;
  localparam reg_idx_t REG_MODE  = 2'd1;
  localparam reg_idx_t REG_FIXED = 2'd2;

  localparam logic [DATA_W-1:0] PAT_EVEN = 32'h5a5a_5a5a;
  localparam logic [DATA_W-1:0] PAT_ODD  = 32'ha5a5_a5a5;

  typedef struct packed {
    logic [ADDR_W-1:0] region_base;
    mode_t             pattern_mode;
    logic [DATA_W-1:0] fixed_pattern;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] expected;
    logic              mismatch;
    logic [DIFF_W-1:0] diff;
    cls_t              cls;
  } chk_t;

endpackage

@@ design/mtpc_if.sv @@
interface mtpc_in_if;
  logic                          valid;
  logic                          ready;
  mtpc_pkg::cmd_t                cmd;
  logic [mtpc_pkg::DATA_W-1:0]   word_offset;
  logic [mtpc_pkg::DATA_W-1:0]   read_word;
  logic                          last_word;

  modport source (output valid, cmd, word_offset, read_word, last_word, input ready);
  modport sink   (input valid, cmd, word_offset, read_word, last_word, output ready);
endinterface

interface mtpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtpc_pkg::DATA_W-1:0]   expected_word;
  logic                          mismatch;
  logic [mtpc_pkg::DIFF_W-1:0]   diff_bits;
  mtpc_pkg::cls_t                error_class;
  logic [mtpc_pkg::CNT_W-1:0]    single_errors;
  logic [mtpc_pkg::CNT_W-1:0]    multi_errors;
  logic                          pass_done;

  modport source (output valid, expected_word, mismatch, diff_bits, error_class,
                  single_errors, multi_errors, pass_done, input ready);
  modport sink   (input valid, expected_word, mismatch, diff_bits, error_class,
                  single_errors, multi_errors, pass_done, output ready);
endinterface

@@ design/mtpc_check.sv @@
module mtpc_check (
  input  mtpc_pkg::cfg_t                cfg,
  input  mtpc_pkg::cmd_t                cmd,
  input  logic [mtpc_pkg::DATA_W-1:0]   word_offset,
  input  logic [mtpc_pkg::DATA_W-1:0]   read_word,
  output mtpc_pkg::chk_t                res
);

  logic [mtpc_pkg::DATA_W-1:0] offset_al;
  logic [2:0]                  addr_lo;
  logic [mtpc_pkg::DATA_W-1:0] expected;
  logic [mtpc_pkg::DATA_W-1:0] xdiff;
  logic [1:0] lvl1 [16];
  logic [2:0] lvl2 [8];
  logic [3:0] lvl3 [4];
  logic [4:0] lvl4 [2];
  logic [mtpc_pkg::DIFF_W-1:0] ones;

  assign offset_al = {word_offset[mtpc_pkg::DATA_W-1:2], 2'b00};
  // only the low three address bits matter for the alternating pattern
  assign addr_lo   = cfg.region_base[2:0] + offset_al[2:0];

  always_comb begin
    if (cfg.pattern_mode[1]) begin
      expected = cfg.fixed_pattern;
    end else if (cfg.pattern_mode == mtpc_pkg::MODE_ALT) begin
      expected = (addr_lo == 3'd0) ? mtpc_pkg::PAT_EVEN : mtpc_pkg::PAT_ODD;
    end else begin
      expected = offset_al;
    end
  end

  assign xdiff = expected ^ read_word;

  // adder tree population count
  always_comb begin
    for (int i = 0; i < 16; i++) lvl1[i] = {1'b0, xdiff[2*i]} + {1'b0, xdiff[2*i+1]};
    for (int i = 0; i < 8; i++)  lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    for (int i = 0; i < 4; i++)  lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    for (int i = 0; i < 2; i++)  lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
    ones = {1'b0, lvl4[0]} + {1'b0, lvl4[1]};
  end

  always_comb begin
    res.expected = expected;
    res.mismatch = 1'b0;
    res.diff     = '0;
    res.cls      = mtpc_pkg::CLS_NONE;
    if (cmd == mtpc_pkg::CMD_CHECK) begin
      res.diff     = ones;
      res.mismatch = (ones != '0);
      if (ones == 6'd1) begin
        res.cls = mtpc_pkg::CLS_SINGLE;
      end else if (ones != '0) begin
        res.cls = mtpc_pkg::CLS_MULTI;
      end
    end
  end

endmodule

@@ design/memory_test_pattern_checker_core.sv @@
// Memory test pattern checker. Each input word carries a command (generate,
// check, clear), a byte offset into the tested region, the word read back and
// an end-of-pass flag; each produces exactly one result word with the expected
// pattern, the compare outcome, both saturating error counters as they stand
// after that word, and the pass flag echoed. Throughput is one word per clock:
// a word is taken into an input register, the pattern, xor, popcount and
// counter update happen in one combinational pass, and the result lands in an
// output register, which drives out valid. The output register decouples the
// sides: a new word is accepted while a result waits, and only a full pipe
// with out.ready low stalls the input. Registers sit on an APB port at 8-byte
// spacing: 0x00 region_base (40 bits), 0x08 pattern_mode, 0x10 fixed_pattern;
// write them only while the pipe is empty.
module memory_test_pattern_checker_core (
  input  logic                             clk,
  input  logic                             rst_n,
  mtpc_in_if.sink                          in_ch,
  mtpc_out_if.source                       out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mtpc_pkg::PADDR_W-1:0]     cfg_paddr,
  input  logic [mtpc_pkg::PDATA_W-1:0]     cfg_pwdata,
  output logic [mtpc_pkg::PDATA_W-1:0]     cfg_prdata,
  output logic                             cfg_pready
);

  // config registers
  mtpc_pkg::cfg_t cfg_r;
  mtpc_pkg::reg_idx_t reg_idx;
  logic cfg_wr;

  // input stage
  logic                        s1_valid_r;
  mtpc_pkg::cmd_t              s1_cmd_r;
  logic [mtpc_pkg::DATA_W-1:0] s1_offset_r;
  logic [mtpc_pkg::DATA_W-1:0] s1_rdata_r;
  logic                        s1_last_r;

  // error counters
  logic [mtpc_pkg::CNT_W-1:0] single_cnt_r, single_cnt_nxt;
  logic [mtpc_pkg::CNT_W-1:0] multi_cnt_r, multi_cnt_nxt;

  // output stage
  logic                        out_valid_r;
  mtpc_pkg::chk_t              out_chk_r;
  logic [mtpc_pkg::CNT_W-1:0]  out_single_r;
  logic [mtpc_pkg::CNT_W-1:0]  out_multi_r;
  logic                        out_last_r;

  mtpc_pkg::chk_t chk;
  logic out_free, s1_adv, in_ready, in_acc;

  // ---------------------------------------------------------------------------
  // APB register file: zero wait states, write on the access phase
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[mtpc_pkg::PADDR_W-1:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        mtpc_pkg::REG_BASE:  cfg_r.region_base   <= cfg_pwdata[mtpc_pkg::ADDR_W-1:0];
        mtpc_pkg::REG_MODE:  cfg_r.pattern_mode  <= cfg_pwdata[mtpc_pkg::MODE_W-1:0];
        mtpc_pkg::REG_FIXED: cfg_r.fixed_pattern <= cfg_pwdata[mtpc_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mtpc_pkg::REG_BASE:
        cfg_prdata = {{(mtpc_pkg::PDATA_W-mtpc_pkg::ADDR_W){1'b0}}, cfg_r.region_base};
      mtpc_pkg::REG_MODE:
        cfg_prdata = {{(mtpc_pkg::PDATA_W-mtpc_pkg::MODE_W){1'b0}}, cfg_r.pattern_mode};
      mtpc_pkg::REG_FIXED:
        cfg_prdata = {{(mtpc_pkg::PDATA_W-mtpc_pkg::DATA_W){1'b0}}, cfg_r.fixed_pattern};
      default:
        cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: two-entry pipe, input stage drains into the output register
  // whenever that register is empty or being taken this cycle.
  // ---------------------------------------------------------------------------
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ready    = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_ch.cmd;
      s1_offset_r <= in_ch.word_offset;
      s1_rdata_r  <= in_ch.read_word;
      s1_last_r   <= in_ch.last_word;
    end
  end

  // pattern, compare, popcount, classify
  mtpc_check u_check (
    .cfg         (cfg_r),
    .cmd         (s1_cmd_r),
    .word_offset (s1_offset_r),
    .read_word   (s1_rdata_r),
    .res         (chk)
  );

  // saturating counters; clear wins over nothing else since one cmd per word
  always_comb begin
    single_cnt_nxt = single_cnt_r;
    multi_cnt_nxt  = multi_cnt_r;
    if (s1_cmd_r == mtpc_pkg::CMD_CLEAR) begin
      single_cnt_nxt = '0;
      multi_cnt_nxt  = '0;
    end else if (chk.cls == mtpc_pkg::CLS_SINGLE) begin
      if (single_cnt_r != '1) single_cnt_nxt = single_cnt_r + 1'b1;
    end else if (chk.cls == mtpc_pkg::CLS_MULTI) begin
      if (multi_cnt_r != '1) multi_cnt_nxt = multi_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_cnt_r <= '0;
      multi_cnt_r  <= '0;
    end else if (s1_adv) begin
      single_cnt_r <= single_cnt_nxt;
      multi_cnt_r  <= multi_cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_chk_r    <= chk;
      out_single_r <= single_cnt_nxt;
      out_multi_r  <= multi_cnt_nxt;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.expected_word = out_chk_r.expected;
  assign out_ch.mismatch      = out_chk_r.mismatch;
  assign out_ch.diff_bits     = out_chk_r.diff;
  assign out_ch.error_class   = out_chk_r.cls;
  assign out_ch.single_errors = out_single_r;
  assign out_ch.multi_errors  = out_multi_r;
  assign out_ch.pass_done     = out_last_r;

endmodule
